/* design/fala_pkg.sv */
// Shared types, threshold table and constants for the flow average level alarm block.
package fala_pkg;

    localparam int FRAC_BITS = 8;
    localparam int ACC_W     = 16 + FRAC_BITS;
    localparam int NUM_ROWS  = 3;
    localparam int NUM_LVLS  = 8;

    typedef logic [ACC_W-1:0] acc_t;
    typedef logic [1:0]       gas_t;
    typedef logic [2:0]       level_t;

    // Gas selector codes.
    localparam gas_t GAS_SF6 = 2'd0;
    localparam gas_t GAS_N2  = 2'd1;
    localparam gas_t GAS_CO2 = 2'd2;

    // 1.30 V in ADC counts.
    localparam logic [15:0] LOW_FLOW_COUNTS = 16'd20800;

    // Level at or above which the alarm is raised.
    localparam level_t ALARM_SET_LEVEL = 3'd6;

    // Gas table thresholds in whole ADC counts (volts times 16000, rounded).
    localparam logic [15:0] THR_COUNTS [NUM_ROWS][NUM_LVLS] = '{
        '{16'd23760, 16'd28544, 16'd32880, 16'd36432,
          16'd39472, 16'd42192, 16'd44624, 16'd46880},
        '{16'd20096, 16'd20736, 16'd21488, 16'd22368,
          16'd23264, 16'd24224, 16'd25168, 16'd26096},
        '{16'd22400, 16'd24000, 16'd25760, 16'd27840,
          16'd29600, 16'd31040, 16'd32480, 16'd33760}
    };

    // Result of the level stage, handed back to the top level registers.
    typedef struct packed {
        logic   low_flow;
        level_t level;
        logic   alarm;
    } fala_status_t;

endpackage

/* design/fala_ema.sv */
// Next value of the exponential moving average accumulator.
module fala_ema #(
    parameter int AVG_SHIFT = 3
) (
    input  logic [15:0]     sample,
    input  fala_pkg::acc_t  acc,
    output fala_pkg::acc_t  acc_next
);
    import fala_pkg::*;

    logic signed [ACC_W:0] diff;
    logic signed [ACC_W:0] step;
    logic signed [ACC_W:0] sum;

    // The arithmetic shift rounds the step towards minus infinity.
    assign diff     = $signed({1'b0, sample, {FRAC_BITS{1'b0}}}) - $signed({1'b0, acc});
    assign step     = diff >>> AVG_SHIFT;
    assign sum      = $signed({1'b0, acc}) + step;
    assign acc_next = sum[ACC_W-1:0];

endmodule

/* design/fala_level.sv */
// Threshold comparison, level selection, low-flow flag and alarm hysteresis.
module fala_level (
    input  fala_pkg::acc_t        acc,
    input  fala_pkg::gas_t        gas_type,
    input  fala_pkg::level_t      level_prev,
    input  logic                  alarm_prev,
    output fala_pkg::fala_status_t status
);
    import fala_pkg::*;

    logic [1:0]          row;
    logic [NUM_LVLS-1:0] below;
    level_t              level_new;
    logic                alarm_new;

    // The unused selector code falls back to the CO2 row.
    assign row = (gas_type > GAS_CO2) ? GAS_CO2 : gas_type;

    always_comb
    begin
        for (int i = 0; i < NUM_LVLS; i++)
        begin
            below[i] = (acc <= {THR_COUNTS[row][i], {FRAC_BITS{1'b0}}});
        end
    end

    // Lowest threshold that the average does not exceed; hold above the top.
    always_comb
    begin
        level_new = level_prev;
        for (int i = NUM_LVLS - 1; i >= 0; i--)
        begin
            if (below[i])
            begin
                level_new = level_t'(i);
            end
        end
    end

    always_comb
    begin
        priority if (level_new == '0)
        begin
            alarm_new = 1'b0;
        end
        else if (level_new >= ALARM_SET_LEVEL)
        begin
            alarm_new = 1'b1;
        end
        else
        begin
            alarm_new = alarm_prev;
        end
    end

    assign status.low_flow = (acc[ACC_W-1:FRAC_BITS] < LOW_FLOW_COUNTS);
    assign status.level    = level_new;
    assign status.alarm    = alarm_new;

endmodule

/* design/flow_average_level_alarm_unit.sv */
// Top level of the flow average, level and alarm block.
//
//  Channel | Signals                                  | Direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_stall, sample               | into block
//  out     | out_valid, out_stall, average, low_flow, | out of block
//          | level, alarm                             |
//  cfg     | cfg_we, cfg_wdata (gas_type)             | into block
//
// A new beat can be taken in every cycle while in_stall is low: the only loop
// is the accumulator update, which closes through one subtract, shift and add
// followed by eight compares.
// An accepted beat moves through the input register, then the result register.
// Reset clears the accumulator, the held level and alarm, and selects SF6.
// A stall on the output holds the result and backs up into the input register
// only once that register is also full, so one waiting result never blocks
// the next beat from entering.
module flow_average_level_alarm_unit #(
    parameter int AVG_SHIFT = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [15:0]           sample,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [15:0]           average,
    output logic                  low_flow,
    output fala_pkg::level_t      level,
    output logic                  alarm,
    input  logic                  cfg_we,
    input  fala_pkg::gas_t        cfg_wdata
);
    import fala_pkg::*;

    // Input register.
    logic         in_full_reg;
    logic [15:0]  sample_reg;

    // State, which doubles as the result register.
    acc_t         acc_reg;
    acc_t         acc_next;
    level_t       level_reg;
    logic         alarm_reg;
    logic         low_flow_reg;
    logic         out_valid_reg;
    gas_t         gas_type_reg;

    fala_status_t status;

    logic         out_free;
    logic         fire;
    logic         in_take;

    // The result register can take a new beat when it is empty or being read.
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = in_full_reg && out_free;
    assign in_stall = in_full_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    fala_ema #(
        .AVG_SHIFT(AVG_SHIFT)
    ) u_ema (
        .sample   (sample_reg),
        .acc      (acc_reg),
        .acc_next (acc_next)
    );

    fala_level u_level (
        .acc        (acc_next),
        .gas_type   (gas_type_reg),
        .level_prev (level_reg),
        .alarm_prev (alarm_reg),
        .status     (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gas_type_reg <= GAS_SF6;
        end
        else if (cfg_we)
        begin
            gas_type_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_full_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_full_reg <= 1'b0;
        end
    end

    // The sample itself is payload and needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg <= sample;
        end
    end

    // The state only moves when a beat passes into the result register, so a
    // stalled result keeps its value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            level_reg     <= '0;
            alarm_reg     <= 1'b0;
            low_flow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            acc_reg       <= acc_next;
            level_reg     <= status.level;
            alarm_reg     <= status.alarm;
            low_flow_reg  <= status.low_flow;
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign average   = acc_reg[ACC_W-1:FRAC_BITS];
    assign low_flow  = low_flow_reg;
    assign level     = level_reg;
    assign alarm     = alarm_reg;

endmodule
